/* rtl/b32dec_pkg.sv */
// ----------------------------------------------------------------------------
// b32dec_pkg
// Shared types, constants and helpers of the Base32 stream decoder.
// ----------------------------------------------------------------------------
package b32dec_pkg;

	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned SYM_W      = 5;
	localparam int unsigned GROUP_W    = 40;
	localparam int unsigned NBYTES_W   = 3;
	localparam int unsigned PADS_W     = 4;
	localparam int unsigned FIFO_DEPTH = 4;

	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_DIGIT_2 = 8'h32;
	localparam logic [CHAR_W-1:0] CH_DIGIT_7 = 8'h37;
	localparam logic [CHAR_W-1:0] CH_PAD     = 8'h3D;
	localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
	localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'd26;

	// Character classes
	typedef enum logic [1:0] {
		CLS_DATA,
		CLS_PAD,
		CLS_SKIP,
		CLS_BAD
	} cls_kind_t;

	typedef struct packed {
		cls_kind_t        kind;
		logic [SYM_W-1:0] value;
	} cls_t;

	// One finished group (or an error marker) handed to the back end
	typedef struct packed {
		logic [GROUP_W-1:0]  bits;
		logic [NBYTES_W-1:0] nbytes;
		logic                err;
	} grp_t;

	// Map one raw character to its class and 5-bit symbol
	function automatic cls_t classify(input logic [CHAR_W-1:0] c);
		cls_t             r;
		logic [CHAR_W-1:0] d;
		r.kind  = CLS_BAD;
		r.value = '0;
		d       = '0;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			d       = c - CH_UPPER_A;
			r.kind  = CLS_DATA;
			r.value = d[SYM_W-1:0];
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			d       = c - CH_LOWER_A;
			r.kind  = CLS_DATA;
			r.value = d[SYM_W-1:0];
		end else if (c >= CH_DIGIT_2 && c <= CH_DIGIT_7) begin
			d       = c - CH_DIGIT_2 + DIGIT_BASE;
			r.kind  = CLS_DATA;
			r.value = d[SYM_W-1:0];
		end else if (c == CH_PAD) begin
			r.kind = CLS_PAD;
		end else if (c == CH_LF || c == CH_CR) begin
			r.kind = CLS_SKIP;
		end
		return r;
	endfunction

	// Byte count of a complete group from its pad count
	function automatic logic [NBYTES_W-1:0] bytes_for_pads(input logic [PADS_W-1:0] pads);
		logic [NBYTES_W-1:0] n;
		case (pads)
			4'd6:    n = 3'd1;
			4'd4:    n = 3'd2;
			4'd3:    n = 3'd3;
			4'd1:    n = 3'd4;
			default: n = 3'd5;
		endcase
		return n;
	endfunction

endpackage

/* rtl/b32dec_in_if.sv */
// ----------------------------------------------------------------------------
// b32dec_in_if
// Character channel: valid/ready handshake with one raw character a word.
// ----------------------------------------------------------------------------
interface b32dec_in_if;

	logic                            valid;
	logic                            ready;
	logic [b32dec_pkg::CHAR_W-1:0]   char_in;

	modport source (output valid, output char_in, input ready);
	modport sink   (input valid, input char_in, output ready);

endinterface

/* rtl/b32dec_out_if.sv */
// ----------------------------------------------------------------------------
// b32dec_out_if
// Byte channel: valid/ready handshake with one decoded byte and flags a word.
// ----------------------------------------------------------------------------
interface b32dec_out_if;

	logic        valid;
	logic        ready;
	logic [7:0]  byte_out;
	logic        last_of_group;
	logic        bad_char;

	modport source (output valid, output byte_out, output last_of_group,
		output bad_char, input ready);
	modport sink   (input valid, input byte_out, input last_of_group,
		input bad_char, output ready);

endinterface

/* rtl/base32_stream_decoder.sv */
// ----------------------------------------------------------------------------
// base32_stream_decoder
// Streaming Base32 decoder: characters in, decoded bytes out.
//
// in_ch carries one character a word; out_ch carries one byte a word with
// last_of_group on the final byte of each 8-character group and bad_char on
// the single error word. cfg_wr_en/cfg_wr_data set ignore_garbage; the user is
// to write it only while idle, which the block itself does not enforce.
// Throughput: one character accepted per cycle unless the group queue is full;
// eight characters yield at most five bytes, and the back end unpacks one byte
// per cycle while out_ch is ready, so in steady state neither limits the other.
// A group's eighth character enters the queue as it is accepted; the group is
// then loaded for unpacking, and its first byte goes to the output register.
// in_ch.ready drops only while the group queue is full, which happens when
// the byte receiver stalls on out_ch; the front end then waits while the
// back end holds its current byte steady.
// Reset clears the partial group, the halt and ignore_garbage; no clearing
// pass is needed. After an error word every later character is taken and
// dropped until reset.
// ----------------------------------------------------------------------------
module base32_stream_decoder #(
	parameter int unsigned FifoDepth = b32dec_pkg::FIFO_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	b32dec_in_if.sink      in_ch,
	b32dec_out_if.source   out_ch,
	input  logic           cfg_wr_en,
	input  logic           cfg_wr_data
);

	logic             push;
	logic             q_full;
	logic             pop;
	logic             not_empty;
	b32dec_pkg::grp_t push_grp;
	b32dec_pkg::grp_t head_grp;

	// Assemble groups
	b32dec_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_full      (q_full),
		.push        (push),
		.push_grp    (push_grp)
	);

	// Queue finished groups
	b32dec_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_grp  (push_grp),
		.full      (q_full),
		.pop       (pop),
		.not_empty (not_empty),
		.head_grp  (head_grp)
	);

	// Unpack bytes
	b32dec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head_grp  (head_grp),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule

/* rtl/b32dec_front.sv */
// ----------------------------------------------------------------------------
// b32dec_front
// Accepts characters, classifies them and assembles 40-bit groups; pushes
// each finished group, or one error marker, into the group queue.
// ----------------------------------------------------------------------------
module b32dec_front (
	input  logic                clk,
	input  logic                arst_n,
	b32dec_in_if.sink           in_ch,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic                q_full,
	output logic                push,
	output b32dec_pkg::grp_t    push_grp
);

	logic [b32dec_pkg::GROUP_W-1:0] bits_q;
	logic [2:0]                     chars_q;
	logic [b32dec_pkg::PADS_W-1:0]  pads_q;
	logic                           halted_q;
	logic                           ignore_q;

	b32dec_pkg::cls_t               cls;
	logic                           take;
	logic                           shift_in;
	logic                           group_done;
	logic                           raise_err;
	logic [b32dec_pkg::GROUP_W-1:0] bits_next;
	logic [b32dec_pkg::PADS_W-1:0]  pads_next;

	// Accept whenever the queue has room for a possible group
	assign in_ch.ready = !q_full;
	assign take        = in_ch.valid && !q_full && !halted_q;

	// Classify and build the next group state
	always_comb begin
		cls        = b32dec_pkg::classify(in_ch.char_in);
		shift_in   = take && (cls.kind == b32dec_pkg::CLS_DATA ||
			cls.kind == b32dec_pkg::CLS_PAD);
		raise_err  = take && cls.kind == b32dec_pkg::CLS_BAD && !ignore_q;
		bits_next  = {bits_q[b32dec_pkg::GROUP_W-b32dec_pkg::SYM_W-1:0],
			(cls.kind == b32dec_pkg::CLS_PAD) ? {b32dec_pkg::SYM_W{1'b0}} : cls.value};
		pads_next  = pads_q + ((cls.kind == b32dec_pkg::CLS_PAD) ?
			b32dec_pkg::PADS_W'(1) : b32dec_pkg::PADS_W'(0));
		group_done = shift_in && (chars_q == 3'd7);
	end

	// Drive the queue write
	always_comb begin
		push            = group_done || raise_err;
		push_grp.err    = raise_err;
		push_grp.bits   = raise_err ? '0 : bits_next;
		push_grp.nbytes = raise_err ? b32dec_pkg::NBYTES_W'(1) :
			b32dec_pkg::bytes_for_pads(pads_next);
	end

	// Hold group state; clear it when a group completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q   <= '0;
			chars_q  <= '0;
			pads_q   <= '0;
			halted_q <= 1'b0;
			ignore_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				ignore_q <= cfg_wr_data;
			end
			if (raise_err) begin
				halted_q <= 1'b1;
			end
			if (group_done) begin
				bits_q  <= '0;
				chars_q <= '0;
				pads_q  <= '0;
			end else if (shift_in) begin
				bits_q  <= bits_next;
				chars_q <= chars_q + 3'd1;
				pads_q  <= pads_next;
			end
		end
	end

endmodule

/* rtl/b32dec_fifo.sv */
// ----------------------------------------------------------------------------
// b32dec_fifo
// Short register queue of finished groups between front and back end.
// ----------------------------------------------------------------------------
module b32dec_fifo #(
	parameter int unsigned Depth = b32dec_pkg::FIFO_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  b32dec_pkg::grp_t    push_grp,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output b32dec_pkg::grp_t    head_grp
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	b32dec_pkg::grp_t mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign full      = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign head_grp  = mem_q[rd_ptr_q];

	// Store pushed groups
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

/* rtl/b32dec_back.sv */
// ----------------------------------------------------------------------------
// b32dec_back
// Unpacks queued groups into bytes, most significant first, through an
// output register that decouples the byte channel.
// ----------------------------------------------------------------------------
module b32dec_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                not_empty,
	input  b32dec_pkg::grp_t    head_grp,
	output logic                pop,
	b32dec_out_if.source        out_ch
);

	logic [b32dec_pkg::GROUP_W-1:0]  bits_q;
	logic [b32dec_pkg::NBYTES_W-1:0] left_q;
	logic                            err_q;
	logic                            work_valid_q;
	logic                            out_valid_q;
	logic [7:0]                      out_byte_q;
	logic                            out_last_q;
	logic                            out_bad_q;

	logic out_free;
	logic emit;
	logic last_byte;

	// Emit one byte whenever the output register frees up
	always_comb begin
		out_free  = !out_valid_q || out_ch.ready;
		emit      = work_valid_q && out_free;
		last_byte = (left_q == b32dec_pkg::NBYTES_W'(1));
		pop       = not_empty && (!work_valid_q || (emit && last_byte));
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.byte_out      = out_byte_q;
	assign out_ch.last_of_group = out_last_q;
	assign out_ch.bad_char      = out_bad_q;

	// Control: working group and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				work_valid_q <= 1'b1;
			end else if (emit && last_byte) begin
				work_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: load a group, shift out a byte at a time
	always_ff @(posedge clk) begin
		if (pop) begin
			bits_q <= head_grp.bits;
			left_q <= head_grp.nbytes;
			err_q  <= head_grp.err;
		end else if (emit) begin
			bits_q <= {bits_q[b32dec_pkg::GROUP_W-9:0], 8'h00};
			left_q <= left_q - b32dec_pkg::NBYTES_W'(1);
		end
		if (emit) begin
			out_byte_q <= bits_q[b32dec_pkg::GROUP_W-1 -: 8];
			out_last_q <= last_byte;
			out_bad_q  <= err_q;
		end
	end

endmodule

/* tb/base32_stream_decoder_tb.sv */
// ----------------------------------------------------------------------------
// base32_stream_decoder_tb
// Self-checking bench for the Base32 stream decoder. Characters are pushed one
// word at a time through the input channel with random gaps. A cycle-free
// decoder model predicts every byte and error word. A checker compares each
// accepted output word against the oldest prediction. Phases cover full and
// padded groups, skipped line breaks, ignored garbage, output back-pressure
// and, last of all, the halt after an invalid character.
// ----------------------------------------------------------------------------
module base32_stream_decoder_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IDLE_LIMIT    = 2000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned LONG_HOLD     = 300;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       bad;
	} byte_word_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	b32dec_in_if  in_ch ();
	b32dec_out_if out_ch ();

	base32_stream_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Decoder model state
	logic [b32dec_pkg::GROUP_W-1:0] grp_bits;
	logic [2:0]                     grp_chars;
	logic [b32dec_pkg::PADS_W-1:0]  grp_pads;
	logic                           stuck;
	logic                           skip_garbage;

	byte_word_t  pending_bytes[$];
	int unsigned mismatches;
	int unsigned items_sent;
	int unsigned idle_cycles;
	int unsigned sink_stall;
	int unsigned sink_hold;
	bit          src_idle;
	bit          snk_idle;

	// Clock: 12 ns period
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Decode one accepted character and queue the words it produces
	task automatic decode_char(input logic [7:0] c);
		b32dec_pkg::cls_kind_t kind;
		logic [4:0]            sym;
		int unsigned           n;
		if (stuck)
			return;
		kind = b32dec_pkg::CLS_BAD;
		sym  = '0;
		if (c >= b32dec_pkg::CH_UPPER_A && c <= b32dec_pkg::CH_UPPER_Z) begin
			kind = b32dec_pkg::CLS_DATA;
			sym  = 5'(c - b32dec_pkg::CH_UPPER_A);
		end else if (c >= b32dec_pkg::CH_LOWER_A && c <= b32dec_pkg::CH_LOWER_Z) begin
			kind = b32dec_pkg::CLS_DATA;
			sym  = 5'(c - b32dec_pkg::CH_LOWER_A);
		end else if (c >= b32dec_pkg::CH_DIGIT_2 && c <= b32dec_pkg::CH_DIGIT_7) begin
			kind = b32dec_pkg::CLS_DATA;
			sym  = 5'(c - b32dec_pkg::CH_DIGIT_2 + b32dec_pkg::DIGIT_BASE);
		end else if (c == b32dec_pkg::CH_PAD) begin
			kind = b32dec_pkg::CLS_PAD;
		end else if (c == b32dec_pkg::CH_LF || c == b32dec_pkg::CH_CR) begin
			kind = b32dec_pkg::CLS_SKIP;
		end
		case (kind)
			b32dec_pkg::CLS_SKIP: return;
			b32dec_pkg::CLS_BAD: begin
				if (!skip_garbage) begin
					stuck = 1'b1;
					pending_bytes.push_back('{data: 8'h00, last: 1'b1, bad: 1'b1});
				end
				return;
			end
			b32dec_pkg::CLS_PAD: begin
				grp_bits = {grp_bits[b32dec_pkg::GROUP_W-6:0], 5'd0};
				grp_pads = grp_pads + 1'b1;
			end
			default: grp_bits = {grp_bits[b32dec_pkg::GROUP_W-6:0], sym};
		endcase
		if (grp_chars != 3'd7) begin
			grp_chars = grp_chars + 1'b1;
			return;
		end
		// Short groups from the pad count
		case (grp_pads)
			4'd6:    n = 1;
			4'd4:    n = 2;
			4'd3:    n = 3;
			4'd1:    n = 4;
			default: n = 5;
		endcase
		for (int k = 0; k < n; k++)
			pending_bytes.push_back('{data: grp_bits[b32dec_pkg::GROUP_W-1-8*k -: 8],
				last: (k == n - 1), bad: 1'b0});
		grp_bits  = '0;
		grp_chars = '0;
		grp_pads  = '0;
	endtask

	// Offer one character word and wait for it to be taken
	task automatic push_char(input logic [7:0] c);
		int unsigned gap;
		gap = src_idle ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.char_in <= c;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		items_sent++;
		decode_char(c);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endtask

	// Drop valid and wait until every queued word is out and the pipe is empty
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_ignore(input logic v);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		skip_garbage = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [7:0] rand_symbol_char();
		int unsigned v;
		v = $urandom_range(0, 31);
		if (v < 26)
			return ($urandom_range(0, 1) ? b32dec_pkg::CH_LOWER_A :
				b32dec_pkg::CH_UPPER_A) + 8'(v);
		return b32dec_pkg::CH_DIGIT_2 + 8'(v - 26);
	endfunction

	// Line break, or any byte at all when garbage is allowed
	function automatic logic [7:0] rand_noise_char(input bit noisy);
		if (noisy && $urandom_range(0, 1))
			return 8'($urandom_range(0, 255));
		return $urandom_range(0, 1) ? b32dec_pkg::CH_LF : b32dec_pkg::CH_CR;
	endfunction

	// Mostly well-formed groups; some with scattered or odd pads, some cut short
	task automatic send_random_group(input bit noisy);
		int unsigned pick;
		int unsigned len;
		int unsigned npad;
		logic [7:0]  c;
		pick = $urandom_range(0, 9);
		len  = 8;
		case ($urandom_range(0, 4))
			0:       npad = 0;
			1:       npad = 1;
			2:       npad = 3;
			3:       npad = 4;
			default: npad = 6;
		endcase
		if (pick == 8)
			len = $urandom_range(1, 7);
		if (pick == 9) begin
			repeat ($urandom_range(1, 4)) push_char(rand_noise_char(noisy));
			return;
		end
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				push_char(rand_noise_char(noisy));
			if (pick <= 5)
				c = (i >= 8 - npad) ? b32dec_pkg::CH_PAD : rand_symbol_char();
			else
				c = ($urandom_range(0, 2) == 0) ? b32dec_pkg::CH_PAD : rand_symbol_char();
			push_char(c);
		end
	endtask

	task automatic run_random(input bit noisy, input int unsigned upto);
		while (items_sent < upto)
			send_random_group(noisy);
	endtask

	// All-ones group, mixed case with line breaks and scattered pads, six pads
	task automatic test_directed_groups();
		send_text("77777777");
		send_text("Aa2z\r\n=Z3=");
		send_text("AA======");
		settle();
	endtask

	// Skip bytes just outside each character range and the byte extremes
	task automatic test_ignored_garbage();
		write_ignore(1'b1);
		send_text("MZ@X[W`6{Y1=8");
		push_char(8'h00);
		push_char(8'hFF);
		push_char(b32dec_pkg::CH_PAD);
		settle();
	endtask

	// Stall the byte side for a long stretch while eight full groups keep coming,
	// more than the queue and the working group can hold
	task automatic test_backpressure();
		settle();
		src_idle  = 1'b0;
		sink_hold = LONG_HOLD;
		repeat (64) push_char(rand_symbol_char());
		src_idle = 1'b1;
		settle();
	endtask

	// Invalid character with reporting on: one error word, then nothing
	task automatic test_halt();
		write_ignore(1'b0);
		send_text("MZX");
		push_char(8'h80);
		repeat (30) push_char(8'($urandom_range(0, 255)));
		write_ignore(1'b1);
		send_text("77777777");
		write_ignore(1'b0);
		send_text("AAAA====");
		settle();
	endtask

	// Byte receiver: random stall per word, plus the long hold when asked
	initial begin : byte_sink
		out_ch.ready = 1'b0;
		sink_stall   = 0;
		sink_hold    = 0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				out_ch.ready <= 1'b0;
			end else if (sink_hold > 0) begin
				sink_hold--;
				out_ch.ready <= 1'b0;
			end else if (sink_stall > 0) begin
				sink_stall--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each accepted word with the oldest prediction
	always @(posedge clk) begin : check_bytes
		byte_word_t want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			sink_stall = snk_idle ? $urandom_range(0, 9) : 0;
			if (pending_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: byte_out=%h last_of_group=%b bad_char=%b",
						out_ch.byte_out, out_ch.last_of_group, out_ch.bad_char);
			end else begin
				want = pending_bytes.pop_front();
				if (out_ch.byte_out !== want.data || out_ch.last_of_group !== want.last ||
						out_ch.bad_char !== want.bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: byte_out=%h/%h last_of_group=%b/%b bad_char=%b/%b",
							out_ch.byte_out, want.data, out_ch.last_of_group, want.last,
							out_ch.bad_char, want.bad);
				end
			end
		end
	end

	// Count cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
				(out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
			$display("base32_stream_decoder_tb NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.char_in = '0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = 1'b0;
		grp_bits      = '0;
		grp_chars     = '0;
		grp_pads      = '0;
		stuck         = 1'b0;
		skip_garbage  = 1'b0;
		mismatches    = 0;
		items_sent    = 0;
		idle_cycles   = 0;
		src_idle      = 1'b1;
		snk_idle      = 1'b1;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_groups();
		test_ignored_garbage();
		run_random(1'b1, 110);
		write_ignore(1'b0);
		src_idle = 1'b0;
		snk_idle = 1'b0;
		run_random(1'b0, 170);
		src_idle = 1'b1;
		snk_idle = 1'b1;
		write_ignore(1'b1);
		run_random(1'b1, 220);
		test_backpressure();
		write_ignore(1'b0);
		run_random(1'b0, 320);
		test_halt();

		repeat (20) @(negedge clk);
		if (pending_bytes.size() != 0)
			$display("%0d predicted words never arrived", pending_bytes.size());
		if (mismatches == 0 && pending_bytes.size() == 0)
			$display("base32_stream_decoder_tb OK");
		else
			$display("base32_stream_decoder_tb NOT OK");
		$finish;
	end

endmodule

/* base32_stream_decoder.f */
rtl/b32dec_pkg.sv
rtl/b32dec_in_if.sv
rtl/b32dec_out_if.sv
rtl/b32dec_front.sv
rtl/b32dec_fifo.sv
rtl/b32dec_back.sv
rtl/base32_stream_decoder.sv
tb/base32_stream_decoder_tb.sv
